// ===== rtl/sfp_pkg.sv =====
`default_nettype none

package sfp_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SYNC  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_SYNC = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_VERSION     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAYLOAD_LEN = 2'd3;

  localparam logic [7:0] RST_FIRST_SYNC  = 8'hA5;
  localparam logic [7:0] RST_SECOND_SYNC = 8'h5A;
  localparam logic [7:0] RST_VERSION     = 8'h02;
  localparam logic [4:0] RST_PAYLOAD_LEN = 5'd12;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic [1:0] {
    SEL_BYTE  = 2'd0,
    SEL_COUNT = 2'd1,
    SEL_ERROR = 2'd2
  } out_sel_t;

  typedef struct packed {
    logic     take_count;
    logic     store_data;
    logic     store_switch;
    logic     read;
    logic     idx_inc;
    out_sel_t sel;
  } sfp_cmd_t;

  typedef struct packed {
    logic sync1_hit;
    logic sync2_hit;
    logic ver_hit;
    logic seq_bad;
    logic len_reached;
    logic emit_done;
  } sfp_status_t;

endpackage

`default_nettype wire

// ===== rtl/sync_frame_parser_with_sequence_check_core.sv =====
`default_nettype none

// Sync frame parser with sequence check. Bytes arrive on rx_byte; the parser
// hunts for two sync bytes and a version byte, then takes a sequence count and
// checks it against the previous count plus one (mod 256). Header and payload
// bytes are taken one per cycle and give no result. A count mismatch gives a
// single error result (kind 1, last 1). The switch byte of a good frame starts
// a run of L+2 results: the L payload bytes, the switch byte, then the count
// byte with last set. Each stored byte is read from the frame store and then
// shown, and no input is taken until the run ends. error_count and wrap_count
// give the low 16 bits of the wrapping counters. Configuration is taken at
// any cycle with cfg_wen high; indexes 0..3 set first sync, second sync,
// version and payload length (0 acts as 1, above MAX_PAYLOAD clamps).

module sync_frame_parser_with_sequence_check_core #(
  parameter int MAX_PAYLOAD   = 16,
  parameter int COUNTER_WIDTH = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_wen,
  input  wire  [sfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [sfp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [7:0]                       rx_byte,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             kind,
  output logic [7:0]                       frame_byte,
  output logic                             last,
  output logic [15:0]                      error_count,
  output logic [15:0]                      wrap_count
);
  import sfp_pkg::*;

  sfp_cmd_t    cmd;
  sfp_status_t status;

  sfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sfp_datapath #(
    .MAX_PAYLOAD   (MAX_PAYLOAD),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .rx_byte     (rx_byte),
    .cmd         (cmd),
    .status      (status),
    .kind        (kind),
    .frame_byte  (frame_byte),
    .last        (last),
    .error_count (error_count),
    .wrap_count  (wrap_count)
  );

endmodule

`default_nettype wire

// ===== rtl/sfp_datapath.sv =====
`default_nettype none

module sfp_datapath #(
  parameter int MAX_PAYLOAD   = 16,
  parameter int COUNTER_WIDTH = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_wen,
  input  wire  [sfp_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire  [sfp_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire  [7:0]                            rx_byte,
  input  sfp_pkg::sfp_cmd_t                     cmd,
  output sfp_pkg::sfp_status_t                  status,
  output logic                                  kind,
  output logic [7:0]                            frame_byte,
  output logic                                  last,
  output logic [15:0]                           error_count,
  output logic [15:0]                           wrap_count
);
  import sfp_pkg::*;

  localparam int DEPTH = MAX_PAYLOAD + 1;
  localparam int PW    = $clog2(DEPTH);
  localparam int LW    = 6;

  logic [7:0] first_sync;
  logic [7:0] second_sync;
  logic [7:0] version;
  logic [4:0] payload_len;

  logic [7:0]               last_seq;
  logic                     seq_valid;
  logic [PW-1:0]            pos;
  logic [PW-1:0]            idx;
  logic [7:0]               rd_data;
  logic [COUNTER_WIDTH-1:0] err_cnt;
  logic [COUNTER_WIDTH-1:0] wrap_cnt;
  logic [7:0]               mem [DEPTH];

  logic [7:0]    expect_seq;
  logic [LW-1:0] eff_len;
  logic [LW-1:0] pos_inc;
  logic [31:0]   err_ext;
  logic [31:0]   wrap_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync  <= RST_FIRST_SYNC;
      second_sync <= RST_SECOND_SYNC;
      version     <= RST_VERSION;
      payload_len <= RST_PAYLOAD_LEN;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_FIRST_SYNC:  first_sync  <= cfg_data;
        CFG_SECOND_SYNC: second_sync <= cfg_data;
        CFG_VERSION:     version     <= cfg_data;
        CFG_PAYLOAD_LEN: payload_len <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    expect_seq = last_seq + 8'd1;
    if (payload_len == 5'd0) begin
      eff_len = LW'(1);
    end else if (LW'(payload_len) > LW'(MAX_PAYLOAD)) begin
      eff_len = LW'(MAX_PAYLOAD);
    end else begin
      eff_len = LW'(payload_len);
    end
    pos_inc = LW'(pos) + LW'(1);
  end

  assign status.sync1_hit   = (rx_byte == first_sync);
  assign status.sync2_hit   = (rx_byte == second_sync);
  assign status.ver_hit     = (rx_byte == version);
  assign status.seq_bad     = seq_valid && (rx_byte != expect_seq);
  assign status.len_reached = (pos_inc >= eff_len);
  assign status.emit_done   = (idx == pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_seq  <= 8'd0;
      seq_valid <= 1'b0;
      pos       <= '0;
      idx       <= '0;
      err_cnt   <= '0;
      wrap_cnt  <= '0;
    end else begin
      if (cmd.take_count) begin
        if (seq_valid && (expect_seq == 8'd0)) begin
          wrap_cnt <= wrap_cnt + COUNTER_WIDTH'(1);
        end
        if (status.seq_bad) begin
          err_cnt   <= err_cnt + COUNTER_WIDTH'(1);
          seq_valid <= 1'b0;
        end else begin
          last_seq  <= rx_byte;
          seq_valid <= 1'b1;
          pos       <= '0;
        end
      end
      if (cmd.store_data) begin
        pos <= pos_inc[PW-1:0];
      end
      if (cmd.store_switch) begin
        idx <= '0;
      end
      if (cmd.idx_inc) begin
        idx <= idx + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_data || cmd.store_switch) begin
      mem[pos] <= rx_byte;
    end
    if (cmd.read) begin
      rd_data <= mem[idx];
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_BYTE: begin
        kind       = KIND_FRAME;
        frame_byte = rd_data;
        last       = 1'b0;
      end
      SEL_COUNT: begin
        kind       = KIND_FRAME;
        frame_byte = last_seq;
        last       = 1'b1;
      end
      SEL_ERROR: begin
        kind       = KIND_ERROR;
        frame_byte = 8'd0;
        last       = 1'b1;
      end
      default: begin
        kind       = KIND_FRAME;
        frame_byte = 8'd0;
        last       = 1'b0;
      end
    endcase
  end

  assign err_ext     = 32'(err_cnt);
  assign wrap_ext    = 32'(wrap_cnt);
  assign error_count = err_ext[15:0];
  assign wrap_count  = wrap_ext[15:0];

`ifndef SYNTH
  a_err_inc: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_count && status.seq_bad) |=> (err_cnt == $past(err_cnt) + COUNTER_WIDTH'(1)))
    else $error("error counter did not advance on a bad count");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.read |-> (idx <= pos))
    else $error("frame store read past the switch byte");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.store_data |-> (LW'(pos) < LW'(MAX_PAYLOAD)))
    else $error("payload write beyond the store");
`endif

endmodule

`default_nettype wire

// ===== rtl/sfp_ctrl.sv =====
`default_nettype none

module sfp_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  input  sfp_pkg::sfp_status_t  status,
  output sfp_pkg::sfp_cmd_t     cmd
);
  import sfp_pkg::*;

  typedef enum logic [9:0] {
    ST_SYNC1   = 10'b0000000001,
    ST_SYNC2   = 10'b0000000010,
    ST_VERSION = 10'b0000000100,
    ST_COUNT   = 10'b0000001000,
    ST_DATA    = 10'b0000010000,
    ST_SWITCH  = 10'b0000100000,
    ST_READ    = 10'b0001000000,
    ST_SHOW    = 10'b0010000000,
    ST_CNT     = 10'b0100000000,
    ST_ERR     = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;
  logic   out_fire;

  assign in_ready  = (state == ST_SYNC1) || (state == ST_SYNC2) || (state == ST_VERSION) ||
                     (state == ST_COUNT) || (state == ST_DATA) || (state == ST_SWITCH);
  assign out_valid = (state == ST_SHOW) || (state == ST_CNT) || (state == ST_ERR);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    state_next       = state;
    cmd.take_count   = 1'b0;
    cmd.store_data   = 1'b0;
    cmd.store_switch = 1'b0;
    cmd.read         = 1'b0;
    cmd.idx_inc      = 1'b0;
    cmd.sel          = SEL_BYTE;
    case (state)
      ST_SYNC1: begin
        if (in_fire && status.sync1_hit) begin
          state_next = ST_SYNC2;
        end
      end
      ST_SYNC2: begin
        if (in_fire) begin
          state_next = status.sync2_hit ? ST_VERSION : ST_SYNC1;
        end
      end
      ST_VERSION: begin
        if (in_fire) begin
          state_next = status.ver_hit ? ST_COUNT : ST_SYNC1;
        end
      end
      ST_COUNT: begin
        if (in_fire) begin
          cmd.take_count = 1'b1;
          state_next     = status.seq_bad ? ST_ERR : ST_DATA;
        end
      end
      ST_DATA: begin
        if (in_fire) begin
          cmd.store_data = 1'b1;
          if (status.len_reached) begin
            state_next = ST_SWITCH;
          end
        end
      end
      ST_SWITCH: begin
        if (in_fire) begin
          cmd.store_switch = 1'b1;
          state_next       = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        cmd.sel = SEL_BYTE;
        if (out_fire) begin
          if (status.emit_done) begin
            state_next = ST_CNT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = ST_READ;
          end
        end
      end
      ST_CNT: begin
        cmd.sel = SEL_COUNT;
        if (out_fire) begin
          state_next = ST_SYNC1;
        end
      end
      ST_ERR: begin
        cmd.sel = SEL_ERROR;
        if (out_fire) begin
          state_next = ST_SYNC1;
        end
      end
      default: begin
        state_next = ST_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SYNC1;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open at once");

  a_err_after_bad: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COUNT && in_fire && status.seq_bad) |=> (state == ST_ERR))
    else $error("bad count did not raise an error result");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_CNT || state == ST_ERR) && out_ready) |=> (state == ST_SYNC1))
    else $error("parser did not return to hunting after a run");
`endif

endmodule

`default_nettype wire
